// ===== src/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication on clk, disabled in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/rrg_pkg.sv =====
// types, codes and constants of the range random generator
`default_nettype none

package rrg_pkg;

    localparam int KBITS    = 28;
    localparam int ROT_BITS = 20;
    localparam int PC_BITS  = 5;

    localparam logic CFG_RANGE_LOW  = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;

    typedef struct packed {
        logic        reseed;
        logic [63:0] seed_value;
    } rrg_in_t;

    typedef struct packed {
        logic [63:0] number;
        logic        range_error;
        logic        drawn;
    } rrg_out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_CTR,
        OP_STORE_CTR,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_SUM,
        OP_ADD,
        OP_XOR,
        OP_ROT,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_RESULT
    } rrg_op_t;

    typedef enum logic [3:0] {
        K_LCG_MUL,
        K_LCG_ADD,
        K_MUL_A,
        K_ADD_A,
        K_XOR_A,
        K_MUL_B,
        K_ADD_B,
        K_XOR_B,
        K_MUL_C,
        K_ADD_C
    } rrg_const_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_LOOP,
        COND_FINISH
    } rrg_cond_t;

    typedef struct packed {
        rrg_op_t    op;
        rrg_const_t kidx;
    } rrg_dp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic finish;
    } rrg_seq_stat_t;

    function automatic logic [KBITS-1:0] k_value(input rrg_const_t k);
        logic [KBITS-1:0] v;
        unique case (k)
            K_LCG_MUL: v = 28'd151117737;
            K_LCG_ADD: v = 28'd119785373;
            K_MUL_A:   v = 28'd119785373;
            K_ADD_A:   v = 28'd126792457;
            K_XOR_A:   v = 28'd187678878;
            K_MUL_B:   v = 28'd85689495;
            K_ADD_B:   v = 28'd63498502;
            K_XOR_B:   v = 28'd143537923;
            K_MUL_C:   v = 28'd151117737;
            K_ADD_C:   v = 28'd98781234;
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/rrg_seq.sv =====
// microcode sequencer: program rom, step counter and loop counter
`default_nettype none

module rrg_seq #(
    parameter int WORD_BITS = 64
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire                   out_free,
    output rrg_pkg::rrg_dp_ctrl_t ctrl,
    output rrg_pkg::rrg_seq_stat_t stat
);

    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);
    localparam logic [rrg_pkg::PC_BITS-1:0] PC_MOD_STEP = 5'd23;
    localparam logic [rrg_pkg::PC_BITS-1:0] PC_END      = 5'd25;

    typedef struct packed {
        rrg_pkg::rrg_op_t              op;
        rrg_pkg::rrg_const_t           kidx;
        rrg_pkg::rrg_cond_t            cond;
        logic [rrg_pkg::PC_BITS-1:0]   target;
    } rrg_uword_t;

    function automatic rrg_uword_t program_word(input logic [rrg_pkg::PC_BITS-1:0] pc);
        rrg_uword_t w;
        w.op     = rrg_pkg::OP_NOP;
        w.kidx   = rrg_pkg::K_LCG_MUL;
        w.cond   = rrg_pkg::COND_NEXT;
        w.target = '0;
        unique case (pc)
            5'd0:  w.op = rrg_pkg::OP_LOAD_CTR;
            5'd1:  begin w.op = rrg_pkg::OP_MUL_LO; w.kidx = rrg_pkg::K_LCG_MUL; end
            5'd2:  begin w.op = rrg_pkg::OP_MUL_HI; w.kidx = rrg_pkg::K_LCG_MUL; end
            5'd3:  w.op = rrg_pkg::OP_MUL_SUM;
            5'd4:  begin w.op = rrg_pkg::OP_ADD; w.kidx = rrg_pkg::K_LCG_ADD; end
            5'd5:  w.op = rrg_pkg::OP_STORE_CTR;
            5'd6:  begin w.op = rrg_pkg::OP_MUL_LO; w.kidx = rrg_pkg::K_MUL_A; end
            5'd7:  begin w.op = rrg_pkg::OP_MUL_HI; w.kidx = rrg_pkg::K_MUL_A; end
            5'd8:  w.op = rrg_pkg::OP_MUL_SUM;
            5'd9:  begin w.op = rrg_pkg::OP_ADD; w.kidx = rrg_pkg::K_ADD_A; end
            5'd10: begin w.op = rrg_pkg::OP_XOR; w.kidx = rrg_pkg::K_XOR_A; end
            5'd11: w.op = rrg_pkg::OP_ROT;
            5'd12: begin w.op = rrg_pkg::OP_MUL_LO; w.kidx = rrg_pkg::K_MUL_B; end
            5'd13: begin w.op = rrg_pkg::OP_MUL_HI; w.kidx = rrg_pkg::K_MUL_B; end
            5'd14: w.op = rrg_pkg::OP_MUL_SUM;
            5'd15: begin w.op = rrg_pkg::OP_ADD; w.kidx = rrg_pkg::K_ADD_B; end
            5'd16: begin w.op = rrg_pkg::OP_XOR; w.kidx = rrg_pkg::K_XOR_B; end
            5'd17: w.op = rrg_pkg::OP_ROT;
            5'd18: begin w.op = rrg_pkg::OP_MUL_LO; w.kidx = rrg_pkg::K_MUL_C; end
            5'd19: begin w.op = rrg_pkg::OP_MUL_HI; w.kidx = rrg_pkg::K_MUL_C; end
            5'd20: w.op = rrg_pkg::OP_MUL_SUM;
            5'd21: begin w.op = rrg_pkg::OP_ADD; w.kidx = rrg_pkg::K_ADD_C; end
            5'd22: w.op = rrg_pkg::OP_MOD_INIT;
            5'd23:
            begin
                w.op     = rrg_pkg::OP_MOD_STEP;
                w.cond   = rrg_pkg::COND_LOOP;
                w.target = PC_MOD_STEP;
            end
            5'd24: w.op = rrg_pkg::OP_RESULT;
            default:
            begin
                w.cond   = rrg_pkg::COND_FINISH;
                w.target = PC_END;
            end
        endcase
        return w;
    endfunction

    logic                        busy_reg, busy_next;
    logic [rrg_pkg::PC_BITS-1:0] pc_reg, pc_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    rrg_uword_t                  word;

    assign word = program_word(pc_reg);

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
                cnt_next  = '0;
            end
        end
        else
        begin
            unique case (word.cond)
                rrg_pkg::COND_NEXT:
                    pc_next = pc_reg + 1'b1;
                rrg_pkg::COND_LOOP:
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_next = '0;
                        pc_next  = pc_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        pc_next  = word.target;
                    end
                end
                rrg_pkg::COND_FINISH:
                begin
                    if (out_free)
                    begin
                        busy_next = 1'b0;
                        pc_next   = '0;
                    end
                    else
                    begin
                        pc_next = word.target;
                    end
                end
                default:
                    pc_next = pc_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_comb
    begin
        ctrl.op     = busy_reg ? word.op : rrg_pkg::OP_NOP;
        ctrl.kidx   = word.kidx;
        stat.busy   = busy_reg;
        stat.finish = busy_reg && (word.cond == rrg_pkg::COND_FINISH) && out_free;
    end

endmodule

`default_nettype wire

// ===== src/rrg_datapath.sv =====
// datapath: counter, accumulator, split multiplier and bit-serial remainder
`default_nettype none

module rrg_datapath #(
    parameter int WORD_BITS = 64
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  rrg_pkg::rrg_dp_ctrl_t       ctrl,
    input  wire                         seed_load,
    input  wire  [WORD_BITS-1:0]        seed,
    input  wire  [WORD_BITS-1:0]        low,
    input  wire  [WORD_BITS-1:0]        span,
    output logic [WORD_BITS-1:0]        result
);

    localparam int HALF = WORD_BITS / 2;
    localparam int HW   = WORD_BITS - HALF;
    localparam int PLW  = HALF + rrg_pkg::KBITS;
    localparam int PHW  = HW + rrg_pkg::KBITS;
    localparam int ROT  = rrg_pkg::ROT_BITS;

    logic [WORD_BITS-1:0] ctr_reg, ctr_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] part_reg, part_next;
    logic [HW-1:0]        hip_reg, hip_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] div_reg, div_next;

    logic [rrg_pkg::KBITS-1:0] kval;
    logic [PLW-1:0]            prod_lo;
    logic [PHW-1:0]            prod_hi;
    logic [WORD_BITS:0]        shifted;
    logic [WORD_BITS:0]        span_x;
    logic [WORD_BITS:0]        diff;

    assign kval    = rrg_pkg::k_value(ctrl.kidx);
    assign prod_lo = PLW'(acc_reg[HALF-1:0]) * PLW'(kval);
    assign prod_hi = PHW'(acc_reg[WORD_BITS-1:HALF]) * PHW'(kval);
    assign shifted = {rem_reg, div_reg[WORD_BITS-1]};
    assign span_x  = {1'b0, span};
    assign diff    = shifted - span_x;

    always_comb
    begin
        ctr_next  = ctr_reg;
        acc_next  = acc_reg;
        part_next = part_reg;
        hip_next  = hip_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        unique case (ctrl.op)
            rrg_pkg::OP_NOP:       ;
            rrg_pkg::OP_LOAD_CTR:  acc_next = ctr_reg;
            rrg_pkg::OP_STORE_CTR: ctr_next = acc_reg;
            rrg_pkg::OP_MUL_LO:    part_next = WORD_BITS'(prod_lo);
            rrg_pkg::OP_MUL_HI:    hip_next = prod_hi[HW-1:0];
            rrg_pkg::OP_MUL_SUM:   acc_next = part_reg + {hip_reg, {HALF{1'b0}}};
            rrg_pkg::OP_ADD:       acc_next = acc_reg + WORD_BITS'(kval);
            rrg_pkg::OP_XOR:       acc_next = acc_reg ^ WORD_BITS'(kval);
            rrg_pkg::OP_ROT:
                acc_next = {acc_reg[WORD_BITS-1-ROT:0], acc_reg[WORD_BITS-1:WORD_BITS-ROT]};
            rrg_pkg::OP_MOD_INIT:
            begin
                rem_next = '0;
                div_next = acc_reg;
            end
            rrg_pkg::OP_MOD_STEP:
            begin
                rem_next = (shifted >= span_x) ? diff[WORD_BITS-1:0]
                                               : shifted[WORD_BITS-1:0];
                div_next = {div_reg[WORD_BITS-2:0], 1'b0};
            end
            rrg_pkg::OP_RESULT:    acc_next = low + rem_reg;
            default:               ;
        endcase
        if (seed_load)
        begin
            ctr_next = seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        part_reg <= part_next;
        hip_reg  <= hip_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign result = acc_reg;

endmodule

`default_nettype wire

// ===== src/range_random_generator.sv =====
// top level of the range random generator
// timing: reseed, empty range and inverted range items give their result in the cycle after they are taken
// a draw runs the LCG step, three mix rounds on the split multiplier, the one-bit-a-cycle
// remainder loop and the result step; no new item is taken while a draw runs or while an
// untaken result blocks the output; other items are taken one a cycle while results drain
// reset: counter 0, range_low 0, range_high 6, no item pending
`default_nettype none

module range_random_generator #(
    parameter int WORD_BITS = 64
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_ready,
    input  rrg_pkg::rrg_in_t  req_data,
    output logic              rsp_valid,
    input  wire               rsp_ready,
    output rrg_pkg::rrg_out_t rsp_data,
    input  wire               cfg_we,
    input  wire               cfg_index,
    input  wire  [63:0]       cfg_wdata
);

    logic [WORD_BITS-1:0] range_low_reg, range_low_next;
    logic [WORD_BITS-1:0] range_high_reg, range_high_next;
    logic                 out_valid_reg, out_valid_next;
    rrg_pkg::rrg_out_t    out_data_reg, out_data_next;

    rrg_pkg::rrg_dp_ctrl_t  ctrl;
    rrg_pkg::rrg_seq_stat_t stat;

    logic                 out_free;
    logic                 accept;
    logic                 start;
    logic                 seed_load;
    logic                 inverted;
    logic                 empty;
    logic [WORD_BITS-1:0] span;
    logic [WORD_BITS-1:0] result;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = !stat.busy && out_free;
    assign accept    = req_valid && req_ready;
    assign inverted  = range_high_reg < range_low_reg;
    assign empty     = range_high_reg == range_low_reg;
    assign span      = range_high_reg - range_low_reg;
    assign seed_load = accept && req_data.reseed;
    assign start     = accept && !req_data.reseed && !inverted && !empty;

    rrg_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    rrg_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .seed_load (seed_load),
        .seed      (req_data.seed_value[WORD_BITS-1:0]),
        .low       (range_low_reg),
        .span      (span),
        .result    (result)
    );

    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rrg_pkg::CFG_RANGE_LOW:  range_low_next  = cfg_wdata[WORD_BITS-1:0];
                rrg_pkg::CFG_RANGE_HIGH: range_high_next = cfg_wdata[WORD_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        priority if (seed_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.number      = '0;
            out_data_next.range_error = 1'b0;
            out_data_next.drawn       = 1'b0;
        end
        else if (accept && !start)
        begin
            out_valid_next            = 1'b1;
            out_data_next.number      = 64'(range_low_reg);
            out_data_next.range_error = inverted;
            out_data_next.drawn       = 1'b1;
        end
        else if (stat.finish)
        begin
            out_valid_next            = 1'b1;
            out_data_next.number      = 64'(result);
            out_data_next.range_error = 1'b0;
            out_data_next.drawn       = 1'b1;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= WORD_BITS'(6);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/rrg_checker.sv =====
// port-level checker for the range random generator, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module rrg_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               req_valid,
    input wire               req_ready,
    input wire               rsp_valid,
    input wire               rsp_ready,
    input rrg_pkg::rrg_out_t rsp_data,
    input wire               cfg_we
);

    logic req_fire;
    logic cfg_seen;
    logic rsp_clean;

    assign req_fire  = req_valid && req_ready;
    assign cfg_seen  = cfg_we;
    assign rsp_clean = (rsp_data.number == 64'd0) && !rsp_data.range_error;

    // a reseed result carries no number and no error
    `ASSERT_SAME(a_reseed_clean, rsp_valid && !rsp_data.drawn, rsp_clean)

    // an error is only ever flagged on a draw
    `ASSERT_SAME(a_error_is_draw, rsp_valid && rsp_data.range_error, rsp_data.drawn)

    // after an item is taken either its result is shown or the block is busy
    `ASSERT_NEXT(a_accept_progress, req_fire && !cfg_seen, rsp_valid || !req_ready)

    // a stalled result holds
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind range_random_generator rrg_checker u_rrg_checker (.*);

`default_nettype wire

// ===== sim/range_random_generator_tb.sv =====
// testbench for range_random_generator: directed table, then random phases checked by a predictor
`default_nettype none

module range_random_generator_tb;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    localparam logic [63:0] STEP_MUL  = 64'd151117737;
    localparam logic [63:0] STEP_ADD  = 64'd119785373;
    localparam logic [63:0] MIX_MUL_A = 64'd119785373;
    localparam logic [63:0] MIX_ADD_A = 64'd126792457;
    localparam logic [63:0] MIX_XOR_A = 64'd187678878;
    localparam logic [63:0] MIX_MUL_B = 64'd85689495;
    localparam logic [63:0] MIX_ADD_B = 64'd63498502;
    localparam logic [63:0] MIX_XOR_B = 64'd143537923;
    localparam logic [63:0] MIX_MUL_C = 64'd151117737;
    localparam logic [63:0] MIX_ADD_C = 64'd98781234;

    localparam int DIR_COUNT       = 23;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int IDLE_SETTLE     = 8;
    localparam int END_SETTLE      = 120;
    localparam int CYCLE_LIMIT     = 1500000;
    localparam int PRINT_LIMIT     = 50;

    typedef enum int {
        SPAN_SMALL,
        SPAN_WIDE,
        SPAN_FULL,
        SPAN_EMPTY,
        SPAN_INVERTED,
        SPAN_UNIT,
        SPAN_POW2,
        SPAN_TOP
    } span_mode_t;

    typedef struct packed {
        logic [63:0]        low;
        logic [63:0]        high;
        logic               reseed;
        logic [63:0]        seed;
        logic               typed;
        rrg_pkg::rrg_out_t  result;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    rrg_pkg::rrg_in_t  req_data = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rrg_pkg::rrg_out_t rsp_data;
    logic              cfg_we = 1'b0;
    logic              cfg_index = rrg_pkg::CFG_RANGE_LOW;
    logic [63:0]       cfg_wdata = '0;

    logic              row_typed = 1'b0;
    rrg_pkg::rrg_out_t row_expect = '0;
    logic              req_take = 1'b0;

    logic [63:0]       model_low = 64'd0;
    logic [63:0]       model_high = 64'd6;
    logic [63:0]       model_counter = 64'd0;
    rrg_pkg::rrg_out_t expected_results [$];

    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                draw_count = 0;
    int                reseed_count = 0;
    int                inverted_count = 0;
    int                empty_count = 0;
    int                setting_count = 0;

    int                stall_left = 0;
    int                ready_mode = 0;

    dir_row_t          directed_rows [0:DIR_COUNT-1];

    range_random_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] scramble_counter(input logic [63:0] value);
        logic [63:0] v;
        v = value * MIX_MUL_A + MIX_ADD_A;
        v = v ^ MIX_XOR_A;
        v = {v[43:0], v[63:44]};
        v = v * MIX_MUL_B + MIX_ADD_B;
        v = v ^ MIX_XOR_B;
        v = {v[43:0], v[63:44]};
        v = v * MIX_MUL_C + MIX_ADD_C;
        return v;
    endfunction

    function automatic rrg_pkg::rrg_out_t predict_number(input rrg_pkg::rrg_in_t item);
        rrg_pkg::rrg_out_t res;
        res.number      = model_low;
        res.range_error = 1'b0;
        res.drawn       = 1'b1;
        if (item.reseed)
        begin
            model_counter = item.seed_value;
            res.number    = '0;
            res.drawn     = 1'b0;
        end
        else if (model_high < model_low)
        begin
            res.range_error = 1'b1;
        end
        else if (model_high != model_low)
        begin
            model_counter = model_counter * STEP_MUL + STEP_ADD;
            res.number = model_low + scramble_counter(model_counter) % (model_high - model_low);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch: %s got %h expected %h", what, got, want);
    endtask

    // sample at the falling edge what the next rising edge will take
    always @(negedge clk)
    begin : monitor
        rrg_pkg::rrg_out_t predicted;
        rrg_pkg::rrg_out_t want;
        req_take = rst_n && req_valid && req_ready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == rrg_pkg::CFG_RANGE_LOW)
                    model_low = cfg_wdata;
                else
                    model_high = cfg_wdata;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", rsp_data.number, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_data.number !== want.number)
                        report_mismatch("number", rsp_data.number, want.number);
                    if (rsp_data.range_error !== want.range_error)
                        report_mismatch("range_error", 64'(rsp_data.range_error),
                                        64'(want.range_error));
                    if (rsp_data.drawn !== want.drawn)
                        report_mismatch("drawn", 64'(rsp_data.drawn), 64'(want.drawn));
                end
            end
            if (req_take)
            begin
                if (req_data.reseed)
                    reseed_count++;
                else if (model_high < model_low)
                    inverted_count++;
                else if (model_high == model_low)
                    empty_count++;
                else
                    draw_count++;
                predicted = predict_number(req_data);
                expected_results.push_back(row_typed ? row_expect : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: always ready, coin flips, or long stalls, in a mode picked anew at random
    always @(posedge clk)
    begin
        if (cycle_count % 512 == 0)
            ready_mode <= $urandom_range(0, 2);
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if (ready_mode == 0)
        begin
            rsp_ready <= 1'b1;
        end
        else if (ready_mode == 1)
        begin
            rsp_ready <= 1'($urandom_range(0, 1));
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(5, 40);
            rsp_ready  <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    task automatic send_item(input rrg_pkg::rrg_in_t item, input logic typed,
                             input rrg_pkg::rrg_out_t want);
        req_valid  <= 1'b1;
        req_data   <= item;
        row_typed  <= typed;
        row_expect <= want;
        @(posedge clk);
        while (!req_take)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        if (req_valid)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_range(input logic [63:0] low, input logic [63:0] high);
        cfg_we    <= 1'b1;
        cfg_index <= rrg_pkg::CFG_RANGE_LOW;
        cfg_wdata <= low;
        @(posedge clk);
        cfg_index <= rrg_pkg::CFG_RANGE_HIGH;
        cfg_wdata <= high;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        setting_count++;
    endtask

    initial
    begin : stimulus
        rrg_pkg::rrg_in_t item;
        logic [63:0]      last_low;
        logic [63:0]      last_high;
        logic [63:0]      new_low;
        logic [63:0]      new_high;
        span_mode_t       mode;
        int               gap;
        int               burst_left;

        directed_rows[0]  = '{64'd0, 64'd6, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[1]  = '{64'd0, 64'd6, 1'b0, ALL_ONES, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[2]  = '{64'd0, 64'd6, 1'b1, 64'd0, 1'b1, '{64'd0, 1'b0, 1'b0}};
        directed_rows[3]  = '{64'd0, 64'd6, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[4]  = '{64'd0, 64'd6, 1'b1, ALL_ONES, 1'b1, '{64'd0, 1'b0, 1'b0}};
        directed_rows[5]  = '{64'd0, 64'd6, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[6]  = '{64'd0, ALL_ONES, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[7]  = '{64'd0, ALL_ONES, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[8]  = '{ALL_ONES, ALL_ONES, 1'b0, 64'd0, 1'b1,
                              '{ALL_ONES, 1'b0, 1'b1}};
        directed_rows[9]  = '{ALL_ONES, 64'd0, 1'b0, 64'd0, 1'b1, '{ALL_ONES, 1'b1, 1'b1}};
        directed_rows[10] = '{64'd5, 64'd5, 1'b0, 64'd0, 1'b1, '{64'd5, 1'b0, 1'b1}};
        directed_rows[11] = '{64'd7, 64'd3, 1'b0, 64'd0, 1'b1, '{64'd7, 1'b1, 1'b1}};
        directed_rows[12] = '{ALL_ONES - 64'd1, ALL_ONES, 1'b0, 64'd0, 1'b1,
                              '{ALL_ONES - 64'd1, 1'b0, 1'b1}};
        directed_rows[13] = '{64'd0, 64'd1, 1'b0, 64'd0, 1'b1, '{64'd0, 1'b0, 1'b1}};
        directed_rows[14] = '{64'd0, 64'd1, 1'b1, 64'h5555_5555_5555_5555, 1'b1,
                              '{64'd0, 1'b0, 1'b0}};
        directed_rows[15] = '{64'd1, ALL_ONES, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[16] = '{ALL_ONES - 64'd1, ALL_ONES - 64'd2, 1'b0, 64'd0, 1'b1,
                              '{ALL_ONES - 64'd1, 1'b1, 1'b1}};
        directed_rows[17] = '{64'd1, 64'd0, 1'b1, 64'd12345, 1'b1, '{64'd0, 1'b0, 1'b0}};
        directed_rows[18] = '{64'd0, TOP_BIT, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[19] = '{TOP_BIT, ALL_ONES, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[20] = '{64'd100, 64'd1100, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};
        directed_rows[21] = '{64'd100, 64'd1100, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
                              '{64'd0, 1'b0, 1'b0}};
        directed_rows[22] = '{64'd100, 64'd1100, 1'b0, 64'd0, 1'b0, '{64'd0, 1'b0, 1'b0}};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        last_low  = 64'd0;
        last_high = 64'd6;
        for (int i = 0; i < DIR_COUNT; i++)
        begin
            if (directed_rows[i].low != last_low || directed_rows[i].high != last_high)
            begin
                wait_idle();
                write_range(directed_rows[i].low, directed_rows[i].high);
                last_low  = directed_rows[i].low;
                last_high = directed_rows[i].high;
            end
            item.reseed     = directed_rows[i].reseed;
            item.seed_value = directed_rows[i].seed;
            send_item(item, directed_rows[i].typed, directed_rows[i].result);
            gap = $urandom_range(0, 3);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        burst_left = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            mode = (phase < 8) ? span_mode_t'(phase) : span_mode_t'($urandom_range(0, 7));
            case (mode)
                SPAN_SMALL:
                begin
                    new_low  = rand64() >> $urandom_range(0, 63);
                    new_high = new_low + 64'($urandom_range(2, 16));
                end
                SPAN_WIDE:
                begin
                    new_low  = rand64();
                    new_high = rand64();
                    if (new_high < new_low)
                        {new_low, new_high} = {new_high, new_low};
                end
                SPAN_FULL:
                begin
                    new_low  = 64'd0;
                    new_high = ALL_ONES;
                end
                SPAN_EMPTY:
                begin
                    new_low  = rand64();
                    new_high = new_low;
                end
                SPAN_INVERTED:
                begin
                    new_low  = ALL_ONES - 64'($urandom_range(0, 1000));
                    new_high = rand64() >> 1;
                end
                SPAN_UNIT:
                begin
                    new_low  = rand64();
                    new_high = new_low + 64'd1;
                end
                SPAN_POW2:
                begin
                    new_low  = 64'd0;
                    new_high = 64'd1 << $urandom_range(1, 63);
                end
                default:
                begin
                    new_low  = ALL_ONES - 64'($urandom_range(1, 5000));
                    new_high = ALL_ONES;
                end
            endcase
            wait_idle();
            write_range(new_low, new_high);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                item.reseed = ($urandom_range(0, 9) == 0);
                case ($urandom_range(0, 7))
                    0: item.seed_value = '0;
                    1: item.seed_value = ALL_ONES;
                    default: item.seed_value = rand64();
                endcase
                send_item(item, 1'b0, '0);
                if (burst_left != 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                                      : $urandom_range(1, 6);
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived", 64'(expected_results.size()), '0);

        $display("covered %0d draws, %0d reseeds, %0d inverted and %0d empty range items",
                 draw_count, reseed_count, inverted_count, empty_count);
        $display("over %0d range settings, %0d mismatches", setting_count, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== range_random_generator.f =====
+incdir+src
src/rrg_pkg.sv
src/rrg_seq.sv
src/rrg_datapath.sv
src/range_random_generator.sv
src/rrg_checker.sv
sim/range_random_generator_tb.sv
